@@ rtl/host_literal_validator_defines.svh @@
// Assertion macros shared by the verification files of the host literal validator.
`ifndef HOST_LITERAL_VALIDATOR_DEFINES_SVH
`define HOST_LITERAL_VALIDATOR_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define HLV_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset
`define HLV_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that also checks across reset
`define HLV_ASSERT_RST(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/hlv_pkg.sv @@
// Shared types, constants and character classes for the host literal validator.
package hlv_pkg;

    // Longest accepted host string; character count saturates one above it
    localparam int MAX_HOST_LENGTH = 64;
    localparam int CNT_W           = $clog2(MAX_HOST_LENGTH + 2);

    // IPv4 limits
    localparam int V4_MAX_DIGITS = 3;
    localparam int V4_LAST_DOT   = 3;
    localparam int OCTET_MAX     = 255;

    // IPv6 limits
    localparam int V6_GROUP_DIGITS = 4;
    localparam int V6_GROUPS_FULL  = 8;
    localparam int V6_GROUPS_DC    = 7;
    localparam int V6_GROUP_SAT    = 15;

    // Hostname label limits
    localparam int LABEL_MAX = 63;
    localparam int LABEL_SAT = 64;

    // Characters of interest
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_DASH  = 8'h2D;

    // One step of the recognizers, driven from the input register
    typedef struct packed {
        logic       advance;
        logic       term;
        logic [7:0] ch;
    } step_t;

    function automatic logic is_dec(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_letter(input logic [7:0] c);
        return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
    endfunction

    function automatic logic is_hexd(input logic [7:0] c);
        return is_dec(c) || ((c >= 8'h61) && (c <= 8'h66)) || ((c >= 8'h41) && (c <= 8'h46));
    endfunction

endpackage

@@ rtl/hlv_v4.sv @@
// Dotted IPv4 recognizer: four octets, 1 to 3 digits, at most 255, no leading zero.
module hlv_v4 (
    input  logic          aclk,
    input  logic          aresetn,
    input  hlv_pkg::step_t step,
    output logic          v4_ok
);

    logic       alive_reg, alive_next;
    logic [1:0] octets_reg, octets_next;
    logic [7:0] value_reg, value_next;
    logic [1:0] digits_reg, digits_next;
    logic       lead_reg, lead_next;

    logic [3:0]  digit;
    logic [11:0] acc;
    logic        octet_ok;

    assign digit    = step.ch[3:0];
    assign acc      = 12'(value_reg) * 12'd10 + 12'(digit);
    assign octet_ok = (digits_reg != 2'd0) && !((digits_reg > 2'd1) && lead_reg);
    assign v4_ok    = alive_reg && octet_ok && (octets_reg == 2'(hlv_pkg::V4_LAST_DOT));

    // Per-character update
    always_comb begin
        alive_next  = alive_reg;
        octets_next = octets_reg;
        value_next  = value_reg;
        digits_next = digits_reg;
        lead_next   = lead_reg;
        if (step.advance) begin
            if (step.term) begin
                alive_next  = 1'b1;
                octets_next = '0;
                value_next  = '0;
                digits_next = '0;
                lead_next   = 1'b0;
            end else if (alive_reg) begin
                if (hlv_pkg::is_dec(step.ch)) begin
                    if ((digits_reg >= 2'(hlv_pkg::V4_MAX_DIGITS)) ||
                        (acc > 12'(hlv_pkg::OCTET_MAX))) begin
                        alive_next = 1'b0;
                    end else begin
                        if (digits_reg == 2'd0) lead_next = (digit == 4'd0);
                        value_next  = acc[7:0];
                        digits_next = digits_reg + 2'd1;
                    end
                end else if (step.ch == hlv_pkg::CH_DOT) begin
                    if (!octet_ok || (octets_reg >= 2'(hlv_pkg::V4_LAST_DOT))) begin
                        alive_next = 1'b0;
                    end else begin
                        octets_next = octets_reg + 2'd1;
                        digits_next = '0;
                        value_next  = '0;
                        lead_next   = 1'b0;
                    end
                end else begin
                    alive_next = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            alive_reg  <= 1'b1;
            octets_reg <= '0;
            value_reg  <= '0;
            digits_reg <= '0;
            lead_reg   <= 1'b0;
        end else begin
            alive_reg  <= alive_next;
            octets_reg <= octets_next;
            value_reg  <= value_next;
            digits_reg <= digits_next;
            lead_reg   <= lead_next;
        end
    end

endmodule

@@ rtl/hlv_v6.sv @@
// IPv6 recognizer: hex groups, at most one double colon, group count check.
module hlv_v6 (
    input  logic          aclk,
    input  logic          aresetn,
    input  hlv_pkg::step_t step,
    output logic          v6_ok
);

    logic       alive_reg, alive_next;
    logic [3:0] groups_reg, groups_next;
    logic [2:0] digits_reg, digits_next;
    logic       pend_reg, pend_next;    // single colon pending
    logic       dc_reg, dc_next;        // double colon seen
    logic       after_reg, after_next;  // last two characters were a double colon

    logic [3:0] groups_inc;
    logic [3:0] groups_end;

    assign groups_inc = (groups_reg < 4'(hlv_pkg::V6_GROUP_SAT)) ? groups_reg + 4'd1 : groups_reg;
    assign groups_end = (digits_reg != 3'd0) ? groups_inc : groups_reg;
    assign v6_ok = alive_reg && !pend_reg &&
                   (dc_reg ? (groups_end <= 4'(hlv_pkg::V6_GROUPS_DC))
                           : (groups_end == 4'(hlv_pkg::V6_GROUPS_FULL)));

    // Per-character update
    always_comb begin
        alive_next  = alive_reg;
        groups_next = groups_reg;
        digits_next = digits_reg;
        pend_next   = pend_reg;
        dc_next     = dc_reg;
        after_next  = after_reg;
        if (step.advance) begin
            if (step.term) begin
                alive_next  = 1'b1;
                groups_next = '0;
                digits_next = '0;
                pend_next   = 1'b0;
                dc_next     = 1'b0;
                after_next  = 1'b0;
            end else if (alive_reg) begin
                if (step.ch == hlv_pkg::CH_COLON) begin
                    if (after_reg) begin
                        alive_next = 1'b0;
                    end else if (pend_reg) begin
                        if (dc_reg) begin
                            alive_next = 1'b0;
                        end else begin
                            if (digits_reg != 3'd0) groups_next = groups_inc;
                            digits_next = '0;
                            pend_next   = 1'b0;
                            dc_next     = 1'b1;
                            after_next  = 1'b1;
                        end
                    end else begin
                        pend_next = 1'b1;
                    end
                end else if (hlv_pkg::is_hexd(step.ch)) begin
                    pend_next  = 1'b0;
                    after_next = 1'b0;
                    if (pend_reg) begin
                        // colon closes the current group
                        if (digits_reg == 3'd0) begin
                            alive_next = 1'b0;
                        end else begin
                            groups_next = groups_inc;
                            digits_next = 3'd1;
                        end
                    end else if (digits_reg >= 3'(hlv_pkg::V6_GROUP_DIGITS)) begin
                        alive_next = 1'b0;
                    end else begin
                        digits_next = digits_reg + 3'd1;
                    end
                end else begin
                    alive_next = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            alive_reg  <= 1'b1;
            groups_reg <= '0;
            digits_reg <= '0;
            pend_reg   <= 1'b0;
            dc_reg     <= 1'b0;
            after_reg  <= 1'b0;
        end else begin
            alive_reg  <= alive_next;
            groups_reg <= groups_next;
            digits_reg <= digits_next;
            pend_reg   <= pend_next;
            dc_reg     <= dc_next;
            after_reg  <= after_next;
        end
    end

endmodule

@@ rtl/hlv_name.sv @@
// Hostname recognizer: labels of 1 to 63 alphanumerics or dashes, last label not numeric.
module hlv_name (
    input  logic          aclk,
    input  logic          aresetn,
    input  hlv_pkg::step_t step,
    output logic          name_ok
);

    logic       alive_reg, alive_next;
    logic [6:0] len_reg, len_next;
    logic       numeric_reg, numeric_next;
    logic       dash_reg, dash_next;

    logic is_dash;
    logic is_dig;
    logic label_ok;

    assign is_dash  = (step.ch == hlv_pkg::CH_DASH);
    assign is_dig   = hlv_pkg::is_dec(step.ch);
    assign label_ok = (len_reg != 7'd0) && (len_reg <= 7'(hlv_pkg::LABEL_MAX)) && !dash_reg;
    assign name_ok  = alive_reg && label_ok && !numeric_reg;

    // Per-character update
    always_comb begin
        alive_next   = alive_reg;
        len_next     = len_reg;
        numeric_next = numeric_reg;
        dash_next    = dash_reg;
        if (step.advance) begin
            if (step.term) begin
                alive_next   = 1'b1;
                len_next     = '0;
                numeric_next = 1'b1;
                dash_next    = 1'b0;
            end else if (alive_reg) begin
                if (step.ch == hlv_pkg::CH_DOT) begin
                    if (!label_ok) begin
                        alive_next = 1'b0;
                    end else begin
                        len_next     = '0;
                        numeric_next = 1'b1;
                        dash_next    = 1'b0;
                    end
                end else if (hlv_pkg::is_letter(step.ch) || is_dig || is_dash) begin
                    if ((len_reg == 7'd0) && is_dash) begin
                        alive_next = 1'b0;
                    end else begin
                        if (!is_dig) numeric_next = 1'b0;
                        dash_next = is_dash;
                        if (len_reg < 7'(hlv_pkg::LABEL_SAT)) len_next = len_reg + 7'd1;
                    end
                end else begin
                    alive_next = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            alive_reg   <= 1'b1;
            len_reg     <= '0;
            numeric_reg <= 1'b1;
            dash_reg    <= 1'b0;
        end else begin
            alive_reg   <= alive_next;
            len_reg     <= len_next;
            numeric_reg <= numeric_next;
            dash_reg    <= dash_next;
        end
    end

endmodule

@@ rtl/host_literal_validator.sv @@
// Host string validator: IPv4, IPv6 and hostname recognizers in parallel.
// A terminator transaction's result passes through the input register, then the result register.
// Throughput: one character transaction per cycle, except that a terminator stalls while the
// result register is full and m_ready is low; the input and result registers run back to back.
// Reset (aresetn low, synchronous): all recognizers restart, no result pending.
module host_literal_validator (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_ch,
    input  logic       s_terminator,
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_host_ok,
    output logic       m_ipv4_ok,
    output logic       m_ipv6_ok,
    output logic       m_hostname_ok
);

    localparam int CW = hlv_pkg::CNT_W;

    logic          in_valid_reg;
    logic [7:0]    ch_reg;
    logic          term_reg;
    logic [CW-1:0] count_reg, count_next;
    logic          out_valid_reg;
    logic          host_reg, v4_reg, v6_reg, name_reg;

    logic           advance;
    hlv_pkg::step_t step;
    logic           v4_raw, v6_raw, name_raw;
    logic           nonempty, len_ok;

    // Input register moves on unless a terminator meets a full result register that m_ready does not drain
    assign advance = in_valid_reg && (!term_reg || !out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign step    = '{advance: advance, term: term_reg, ch: ch_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            ch_reg   <= s_ch;
            term_reg <= s_terminator;
        end
    end

    hlv_v4 u_v4 (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .v4_ok   (v4_raw)
    );

    hlv_v6 u_v6 (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .v6_ok   (v6_raw)
    );

    hlv_name u_name (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .name_ok (name_raw)
    );

    // Saturating character count
    always_comb begin
        count_next = count_reg;
        if (advance) begin
            if (term_reg) begin
                count_next = '0;
            end else if (count_reg <= CW'(hlv_pkg::MAX_HOST_LENGTH)) begin
                count_next = count_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    assign nonempty = (count_reg != '0);
    assign len_ok   = nonempty && (count_reg <= CW'(hlv_pkg::MAX_HOST_LENGTH));

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance && term_reg) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && term_reg) begin
            host_reg <= len_ok && ((nonempty && (v4_raw || v6_raw)) || name_raw);
            v4_reg   <= nonempty && v4_raw;
            v6_reg   <= nonempty && v6_raw;
            name_reg <= len_ok && name_raw;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_host_ok     = host_reg;
    assign m_ipv4_ok     = v4_reg;
    assign m_ipv6_ok     = v6_reg;
    assign m_hostname_ok = name_reg;

endmodule

@@ rtl/hlv_checker.sv @@
// Port-level checks for the host literal validator, bound to the top level.
`include "host_literal_validator_defines.svh"

module hlv_port_checks (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input logic [7:0] s_ch,
    input logic       s_terminator,
    input logic       m_valid,
    input logic       m_ready,
    input logic       m_host_ok,
    input logic       m_ipv4_ok,
    input logic       m_ipv6_ok,
    input logic       m_hostname_ok
);

    // A stalled result stays put
    `HLV_ASSERT_NEXT(a_hold_valid, m_valid && !m_ready, m_valid, "result dropped while stalled")
    `HLV_ASSERT_NEXT(a_hold_data, m_valid && !m_ready,
        $stable(m_host_ok) && $stable(m_ipv4_ok) && $stable(m_ipv6_ok) &&
        $stable(m_hostname_ok), "result changed while stalled")

    // Overall flag needs at least one recognizer
    `HLV_ASSERT_NOW(a_host_any, m_valid && m_host_ok,
        m_ipv4_ok || m_ipv6_ok || m_hostname_ok, "host_ok without a recognizer")

    // A dotted IPv4 literal is neither IPv6 nor a hostname
    `HLV_ASSERT_NOW(a_v4_excl, m_valid && m_ipv4_ok,
        !m_ipv6_ok && !m_hostname_ok, "IPv4 flag overlaps another recognizer")

    // No result right after reset
    `HLV_ASSERT_RST(a_reset, !aresetn, !m_valid, "result valid after reset")

endmodule

bind host_literal_validator hlv_port_checks u_hlv_port_checks (.*);

@@ tb/hlv_checker.sv @@
// Channel monitor, host string predictor and result scoreboard for the host literal validator.
module hlv_checker
    import hlv_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    input  logic       s_ready,
    input  logic [7:0] s_ch,
    input  logic       s_terminator,
    input  logic       m_valid,
    input  logic       m_ready,
    input  logic       m_host_ok,
    input  logic       m_ipv4_ok,
    input  logic       m_ipv6_ok,
    input  logic       m_hostname_ok,
    output int         fail_count,
    output int         verdicts_owed,
    output int         hosts_checked,
    output int         v4_hits,
    output int         v6_hits,
    output int         name_hits
);

    // Character codes used by the predictor
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_F = 8'h66;
    localparam logic [7:0] CH_LOWER_Z = 8'h7A;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_F = 8'h46;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;

    typedef struct packed {
        logic host;
        logic v4;
        logic v6;
        logic name;
    } verdict_t;

    verdict_t verdict_q[$];
    int       errs = 0;
    int       n_checked = 0;
    int       n_v4 = 0;
    int       n_v6 = 0;
    int       n_name = 0;

    // Predictor state: length, dotted quad, colon hex, label scan
    int   host_len;
    logic v4_live;
    int   v4_dots;
    int   v4_val;
    int   v4_ndig;
    logic v4_lz;
    logic v6_live;
    int   v6_grp;
    int   v6_ndig;
    logic v6_pend;
    logic v6_dbl;
    logic v6_after;
    logic nm_live;
    int   lbl_len;
    logic lbl_numeric;
    logic lbl_dash;

    function automatic logic digit_char(input logic [7:0] c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    function automatic logic alpha_char(input logic [7:0] c);
        return (c >= CH_LOWER_A && c <= CH_LOWER_Z) || (c >= CH_UPPER_A && c <= CH_UPPER_Z);
    endfunction

    function automatic logic hex_char(input logic [7:0] c);
        return digit_char(c) || (c >= CH_LOWER_A && c <= CH_LOWER_F) ||
               (c >= CH_UPPER_A && c <= CH_UPPER_F);
    endfunction

    function automatic logic octet_done();
        return v4_ndig != 0 && !(v4_ndig > 1 && v4_lz);
    endfunction

    function automatic logic label_done();
        return lbl_len != 0 && lbl_len <= LABEL_MAX && !lbl_dash;
    endfunction

    task automatic clear_host();
        host_len = 0;
        v4_live = 1'b1; v4_dots = 0; v4_val = 0; v4_ndig = 0; v4_lz = 1'b0;
        v6_live = 1'b1; v6_grp = 0; v6_ndig = 0;
        v6_pend = 1'b0; v6_dbl = 1'b0; v6_after = 1'b0;
        nm_live = 1'b1; lbl_len = 0; lbl_numeric = 1'b1; lbl_dash = 1'b0;
    endtask

    // Dotted quad: digits accumulate into an octet, dots close it
    task automatic scan_v4(input logic [7:0] c);
        int digit;
        int acc;
        if (!v4_live) return;
        if (digit_char(c)) begin
            digit = int'(c) - int'(CH_ZERO);
            acc = v4_val * 10 + digit;
            if (v4_ndig >= V4_MAX_DIGITS || acc > OCTET_MAX) begin
                v4_live = 1'b0;
            end else begin
                if (v4_ndig == 0) v4_lz = (digit == 0);
                v4_val = acc;
                v4_ndig++;
            end
        end else if (c == CH_DOT) begin
            if (!octet_done() || v4_dots >= V4_LAST_DOT) begin
                v4_live = 1'b0;
            end else begin
                v4_dots++;
                v4_ndig = 0;
                v4_val = 0;
                v4_lz = 1'b0;
            end
        end else begin
            v4_live = 1'b0;
        end
    endtask

    // Colon hex: a colon is held pending until the next character decides
    task automatic scan_v6(input logic [7:0] c);
        if (!v6_live) return;
        if (c == CH_COLON) begin
            if (v6_after) begin
                v6_live = 1'b0;
            end else if (v6_pend) begin
                if (v6_dbl) begin
                    v6_live = 1'b0;
                end else begin
                    if (v6_ndig > 0 && v6_grp < V6_GROUP_SAT) v6_grp++;
                    v6_ndig = 0;
                    v6_pend = 1'b0;
                    v6_dbl = 1'b1;
                    v6_after = 1'b1;
                end
            end else begin
                v6_pend = 1'b1;
            end
        end else if (hex_char(c)) begin
            if (v6_pend && v6_ndig == 0) begin
                v6_live = 1'b0;
            end else begin
                if (v6_pend) begin
                    if (v6_grp < V6_GROUP_SAT) v6_grp++;
                    v6_ndig = 0;
                end
                v6_pend = 1'b0;
                v6_after = 1'b0;
                if (v6_ndig >= V6_GROUP_DIGITS) v6_live = 1'b0;
                else v6_ndig++;
            end
        end else begin
            v6_live = 1'b0;
        end
    endtask

    // Hostname labels
    task automatic scan_name(input logic [7:0] c);
        if (!nm_live) return;
        if (c == CH_DOT) begin
            if (!label_done()) begin
                nm_live = 1'b0;
            end else begin
                lbl_len = 0;
                lbl_numeric = 1'b1;
                lbl_dash = 1'b0;
            end
        end else if (alpha_char(c) || digit_char(c) || c == CH_DASH) begin
            if (lbl_len == 0 && c == CH_DASH) begin
                nm_live = 1'b0;
            end else begin
                if (!digit_char(c)) lbl_numeric = 1'b0;
                lbl_dash = (c == CH_DASH);
                if (lbl_len < LABEL_SAT) lbl_len++;
            end
        end else begin
            nm_live = 1'b0;
        end
    endtask

    // End of string: form the flags and restart every recognizer
    task automatic judge_host(output verdict_t v);
        logic nonempty;
        int   groups;
        nonempty = host_len != 0;
        v.v4 = nonempty && v4_live && octet_done() && v4_dots == V4_LAST_DOT;
        v.v6 = 1'b0;
        if (nonempty && v6_live && !v6_pend) begin
            groups = v6_grp;
            if (v6_ndig > 0 && groups < V6_GROUP_SAT) groups++;
            v.v6 = v6_dbl ? (groups <= V6_GROUPS_DC) : (groups == V6_GROUPS_FULL);
        end
        v.name = nonempty && nm_live && label_done() && host_len <= MAX_HOST_LENGTH &&
                 !lbl_numeric;
        v.host = nonempty && host_len <= MAX_HOST_LENGTH && (v.v4 || v.v6 || v.name);
        clear_host();
    endtask

    always @(posedge aclk) begin
        verdict_t want;
        verdict_t got;
        if (!aresetn) begin
            clear_host();
            verdict_q.delete();
        end else begin
            // Result side: compare against the oldest prediction
            if (m_valid && m_ready) begin
                got = '{m_host_ok, m_ipv4_ok, m_ipv6_ok, m_hostname_ok};
                if (verdict_q.size() == 0) begin
                    $error("result transaction with no terminator outstanding");
                    errs++;
                end else begin
                    want = verdict_q.pop_front();
                    n_checked++;
                    if (want.v4) n_v4++;
                    if (want.v6) n_v6++;
                    if (want.name) n_name++;
                    if (got.host !== want.host) begin
                        $error("host_ok: expected %0b, actual %0b", want.host, got.host);
                        errs++;
                    end
                    if (got.v4 !== want.v4) begin
                        $error("ipv4_ok: expected %0b, actual %0b", want.v4, got.v4);
                        errs++;
                    end
                    if (got.v6 !== want.v6) begin
                        $error("ipv6_ok: expected %0b, actual %0b", want.v6, got.v6);
                        errs++;
                    end
                    if (got.name !== want.name) begin
                        $error("hostname_ok: expected %0b, actual %0b", want.name, got.name);
                        errs++;
                    end
                end
            end
            // Input side: advance the predictor on every accepted transaction
            if (s_valid && s_ready) begin
                if (s_terminator) begin
                    judge_host(want);
                    verdict_q.push_back(want);
                end else begin
                    if (host_len <= MAX_HOST_LENGTH) host_len++;
                    scan_v4(s_ch);
                    scan_v6(s_ch);
                    scan_name(s_ch);
                end
            end
        end
        fail_count    <= errs;
        verdicts_owed <= verdict_q.size();
        hosts_checked <= n_checked;
        v4_hits       <= n_v4;
        v6_hits       <= n_v6;
        name_hits     <= n_name;
    end

endmodule

@@ tb/tb.sv @@
// Top-level testbench for the host literal validator: clock, reset, host string stimulus, verdict.
module tb;
    import hlv_pkg::*;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int HOLD_CYCLES    = 400;
    localparam int DRAIN_CYCLES   = 10;
    localparam int PHASE_ITEMS    = 40;
    localparam string HEX_CHARS   = "0123456789abcdefABCDEF";
    localparam string ALNUM_CHARS =
        "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789";

    logic       aclk;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    logic [7:0] s_ch;
    logic       s_terminator;
    logic       m_valid;
    logic       m_ready;
    logic       m_host_ok;
    logic       m_ipv4_ok;
    logic       m_ipv6_ok;
    logic       m_hostname_ok;

    int fail_count;
    int verdicts_owed;
    int hosts_checked;
    int v4_hits;
    int v6_hits;
    int name_hits;

    int in_idle_pct = 0;
    int out_stall_pct = 0;
    int hold_asks = 0;
    int chars_sent = 0;
    int items_sent = 0;

    logic [7:0] host_chars[$];

    host_literal_validator u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_ch          (s_ch),
        .s_terminator  (s_terminator),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_host_ok     (m_host_ok),
        .m_ipv4_ok     (m_ipv4_ok),
        .m_ipv6_ok     (m_ipv6_ok),
        .m_hostname_ok (m_hostname_ok)
    );

    hlv_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_ch          (s_ch),
        .s_terminator  (s_terminator),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_host_ok     (m_host_ok),
        .m_ipv4_ok     (m_ipv4_ok),
        .m_ipv6_ok     (m_ipv6_ok),
        .m_hostname_ok (m_hostname_ok),
        .fail_count    (fail_count),
        .verdicts_owed (verdicts_owed),
        .hosts_checked (hosts_checked),
        .v4_hits       (v4_hits),
        .v6_hits       (v6_hits),
        .name_hits     (name_hits)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Result side: random stalls, plus a long hold-off whenever one is requested
    initial begin
        int holds_done;
        holds_done = 0;
        m_ready = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_asks != holds_done) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                holds_done++;
            end
            m_ready <= ($urandom_range(99) >= out_stall_pct);
        end
    end

    // Watchdog: too many cycles without any transaction ends the run
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) quiet = 0;
            else quiet++;
        end
        $display("tb failed");
        $finish;
    end

    // One input transaction; valid drops only when the sender goes idle
    task automatic push(input logic [7:0] c, input logic term);
        if (in_idle_pct != 0 && $urandom_range(99) < in_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < in_idle_pct);
        end
        s_valid      <= 1'b1;
        s_ch         <= c;
        s_terminator <= term;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
        if (!term) chars_sent++;
    endtask

    // Send the buffered string followed by a terminator with junk in ch
    task automatic send_host();
        logic [7:0] junk;
        junk = 8'($urandom_range(255));
        foreach (host_chars[i]) push(host_chars[i], 1'b0);
        push(junk, 1'b1);
        host_chars.delete();
    endtask

    task automatic add_char(input logic [7:0] c);
        host_chars.push_back(c);
    endtask

    task automatic add_text(input string t);
        for (int i = 0; i < t.len(); i++) host_chars.push_back(t[i]);
    endtask

    task automatic send_text(input string t);
        add_text(t);
        send_host();
    endtask

    task automatic add_run(input logic [7:0] c, input int n);
        repeat (n) host_chars.push_back(c);
    endtask

    function automatic logic [7:0] rand_letter();
        return ALNUM_CHARS[$urandom_range(51)];
    endfunction

    // Dotted quad with occasional out-of-range or zero-padded octets, or a wrong octet count
    task automatic build_v4();
        int n;
        int pick;
        n = ($urandom_range(9) == 0) ? $urandom_range(3, 5) : 4;
        for (int i = 0; i < n; i++) begin
            if (i != 0) add_char(CH_DOT);
            pick = $urandom_range(19);
            if (pick == 0) add_text($sformatf("%0d", $urandom_range(256, 999)));
            else if (pick == 1) add_text($sformatf("0%0d", $urandom_range(9)));
            else if (pick == 2) add_text("255");
            else add_text($sformatf("%0d", $urandom_range(255)));
        end
    endtask

    // Colon hex, full form or compressed at a random point; now and then a wrong group count or a five-digit group
    task automatic build_v6();
        logic dbl;
        int   total;
        int   dc_at;
        int   len;
        dbl = 1'($urandom_range(1));
        if (dbl) total = $urandom_range(7);
        else total = ($urandom_range(9) == 0) ? $urandom_range(6, 9) : 8;
        dc_at = $urandom_range(total);
        for (int i = 0; i < total; i++) begin
            if (dbl && i == dc_at) add_text("::");
            else if (i != 0) add_char(CH_COLON);
            len = ($urandom_range(19) == 0) ? 5 : $urandom_range(1, 4);
            repeat (len) add_char(HEX_CHARS[$urandom_range(21)]);
        end
        if (dbl && dc_at == total) add_text("::");
    endtask

    // Dotted labels; dashes mostly inside, sometimes an all-digit last label
    task automatic build_name();
        int nlab;
        int len;
        logic sloppy;
        logic numeric_tail;
        nlab = $urandom_range(1, 4);
        sloppy = ($urandom_range(9) == 0);
        numeric_tail = ($urandom_range(7) == 0);
        for (int i = 0; i < nlab; i++) begin
            if (i != 0) add_char(CH_DOT);
            len = $urandom_range(1, 10);
            for (int j = 0; j < len; j++) begin
                if (numeric_tail && i == nlab - 1)
                    add_char(CH_ZERO + 8'($urandom_range(9)));
                else if ((sloppy || (j != 0 && j != len - 1)) && $urandom_range(4) == 0)
                    add_char(CH_DASH);
                else
                    add_char(ALNUM_CHARS[$urandom_range(61)]);
            end
        end
    endtask

    // Names near the length limit, or a single label near the label limit
    task automatic build_long();
        int target;
        int lab;
        if ($urandom_range(3) == 0) begin
            add_run(rand_letter(), $urandom_range(62, 65));
        end else begin
            target = $urandom_range(56, 72);
            while (host_chars.size() < target) begin
                if (host_chars.size() != 0) add_char(CH_DOT);
                lab = $urandom_range(1, LABEL_MAX);
                if (lab > target - host_chars.size()) lab = target - host_chars.size();
                if (lab < 1) lab = 1;
                repeat (lab) add_char(rand_letter());
            end
        end
    endtask

    // Damage one position: overwrite, drop or insert
    task automatic mutate();
        int pos;
        logic [7:0] c;
        case ($urandom_range(3))
            0: c = CH_COLON;
            1: c = CH_DOT;
            2: c = CH_DASH;
            default: c = 8'($urandom_range(255));
        endcase
        pos = $urandom_range(host_chars.size() - 1);
        case ($urandom_range(2))
            0: host_chars[pos] = c;
            1: host_chars.delete(pos);
            default: host_chars.insert(pos, c);
        endcase
    endtask

    task automatic random_host();
        int pick;
        pick = $urandom_range(99);
        if (pick < 25) build_v4();
        else if (pick < 50) build_v6();
        else if (pick < 78) build_name();
        else if (pick < 88) build_long();
        else repeat ($urandom_range(6)) add_char(8'($urandom_range(255)));
        if (host_chars.size() != 0 && $urandom_range(4) == 0) mutate();
        send_host();
    endtask

    task automatic directed_hosts();
        send_text("");
        send_text("255.255.255.255");
        send_text("0.0.0.0");
        send_text("256.1.1.1");
        send_text("01.2.3.4");
        send_text("1.2.3");
        send_text("1.2.3.4.5");
        send_text("1:2:3:4:5:6:7:8");
        send_text("::");
        send_text("::1");
        send_text("1:::2");
        send_text(":1:2:3:4:5:6:7");
        send_text("1:2:3:4:5:6:7:");
        send_text("12345::");
        send_text("1::2::3");
        send_text("1:2:3:4::5:6:7:8");
        // group count saturates well past eight
        send_text("1:1:1:1:1:1:1:1:1:1:1:1:1:1:1:1");
        send_text("Example-1.COM");
        send_text("-a.com");
        send_text("a-.com");
        send_text("a..b");
        send_text("123.456");
        // label of exactly 63, then one of 64
        add_run("q", LABEL_MAX); add_text(".x"); send_host();
        add_run("q", LABEL_SAT); send_host();
        // full length, then one character over
        add_run("h", MAX_HOST_LENGTH); send_host();
        add_run("h", MAX_HOST_LENGTH + 1); send_host();
        // NUL and high bytes are ordinary, invalid characters
        add_text("a"); add_char(8'h00); add_text("b"); send_host();
        add_char(8'hFF); add_char(8'h80); send_host();
    endtask

    initial begin
        int goal;
        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_ch         = 8'h00;
        s_terminator = 1'b0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        directed_hosts();

        // Four idling mixes of random strings, with the long hold-off after the first
        goal = items_sent;
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin in_idle_pct = 0;  out_stall_pct = 0;  end
                1: begin in_idle_pct = 61; out_stall_pct = 0;  end
                2: begin in_idle_pct = 0;  out_stall_pct = 61; end
                default: begin in_idle_pct = 33; out_stall_pct = 33; end
            endcase
            goal = items_sent + PHASE_ITEMS;
            while (items_sent < goal) random_host();
            if (ph == 0) begin
                // short strings back to back while results back up
                hold_asks++;
                for (int k = 0; k < 40; k++) begin
                    if (k % 2 == 0) send_text("");
                    else send_text("a");
                end
            end
        end

        s_valid <= 1'b0;
        // let the last terminator reach the scoreboard count first
        @(posedge aclk);
        while (verdicts_owed != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("covered %0d host strings, %0d characters, under four idling mixes",
                 hosts_checked, chars_sent);
        $display("and one output hold-off; accepted ipv4 %0d, ipv6 %0d, hostname %0d",
                 v4_hits, v6_hits, name_hits);
        if (fail_count == 0) $display("tb passed");
        else $display("tb failed");
        $finish;
    end

endmodule
